// ===== design/ptob_pkg.sv =====
// Shared types and constants for the price-time order book.
package ptob_pkg;

  localparam int BOOK_DEPTH = 64;

  localparam int PRICE_W = 32;
  localparam int ID_W    = 32;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMPACT,
    ST_REPORT
  } state_t;

  // one resting order as held in a cell
  typedef struct packed {
    logic               valid;
    logic               dead;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } entry_t;

  // per-cycle command broadcast to every cell of one side
  typedef struct packed {
    logic               ins_en;
    logic               mark_en;
    logic               shift_en;
    logic [PRICE_W-1:0] key_price;
    logic [ID_W-1:0]    key_id;
  } cmd_t;

  // side status gathered from a chain
  typedef struct packed {
    logic full;
    logic any_match;
    logic any_dead;
  } chain_stat_t;

endpackage

// ===== design/ptob_cell.sv =====
// One slot of a sorted book side: holds an order and trades it with its neighbors.
module ptob_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             is_ask,
  input  ptob_pkg::cmd_t   cmd,
  input  ptob_pkg::entry_t prev_entry,
  input  logic             prev_ins,
  input  logic             prev_seen,
  input  ptob_pkg::entry_t next_entry,
  output ptob_pkg::entry_t entry,
  output logic             ins,
  output logic             seen,
  output logic             match
);

  logic behind;
  ptob_pkg::entry_t entry_next;

  // resting price ranks strictly behind the incoming one
  assign behind = is_ask ? (entry.price > cmd.key_price) : (entry.price < cmd.key_price);
  assign ins    = !entry.valid || behind;
  assign match  = entry.valid && (entry.price == cmd.key_price) && (entry.id == cmd.key_id);
  // a marked entry at or before this slot: this slot pulls from above
  assign seen   = prev_seen || entry.dead;

  always_comb begin
    entry_next = entry;
    if (cmd.ins_en && ins) begin
      if (prev_ins) begin
        entry_next = prev_entry;
      end else begin
        entry_next.valid = 1'b1;
        entry_next.dead  = 1'b0;
        entry_next.price = cmd.key_price;
        entry_next.id    = cmd.key_id;
      end
    end else if (cmd.mark_en) begin
      entry_next.dead = match;
    end else if (cmd.shift_en && seen) begin
      entry_next = next_entry;
    end
  end

  // only the flags are reset; price and id are ignored while the slot is empty
  always_ff @(posedge clk) begin
    entry.price <= entry_next.price;
    entry.id    <= entry_next.id;
    if (rst) begin
      entry.valid <= 1'b0;
      entry.dead  <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
      entry.dead  <= entry_next.dead;
    end
  end

endmodule

// ===== design/ptob_chain.sv =====
// Row of cells forming one side of the book, best order in cell 0.
module ptob_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  is_ask,
  input  ptob_pkg::cmd_t        cmd,
  output ptob_pkg::entry_t      head,
  output ptob_pkg::chain_stat_t stat
);

  localparam int N = ptob_pkg::BOOK_DEPTH;

  ptob_pkg::entry_t cell_entry [N];
  ptob_pkg::entry_t prev_entry [N];
  ptob_pkg::entry_t next_entry [N];
  logic [N-1:0] ins_vec;
  logic [N-1:0] seen_vec;
  logic [N-1:0] match_vec;
  logic [N-1:0] dead_vec;
  logic [N-1:0] prev_ins_vec;
  logic [N-1:0] prev_seen_vec;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_entry[i]    = '0;
      assign prev_ins_vec[i]  = 1'b0;
      assign prev_seen_vec[i] = 1'b0;
    end else begin : g_mid
      assign prev_entry[i]    = cell_entry[i-1];
      assign prev_ins_vec[i]  = ins_vec[i-1];
      assign prev_seen_vec[i] = seen_vec[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_entry[i] = '0;
    end else begin : g_inner
      assign next_entry[i] = cell_entry[i+1];
    end

    assign dead_vec[i] = cell_entry[i].dead;

    ptob_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .is_ask     (is_ask),
      .cmd        (cmd),
      .prev_entry (prev_entry[i]),
      .prev_ins   (prev_ins_vec[i]),
      .prev_seen  (prev_seen_vec[i]),
      .next_entry (next_entry[i]),
      .entry      (cell_entry[i]),
      .ins        (ins_vec[i]),
      .seen       (seen_vec[i]),
      .match      (match_vec[i])
    );
  end

  assign head           = cell_entry[0];
  assign stat.full      = cell_entry[N-1].valid;
  assign stat.any_match = |match_vec;
  assign stat.any_dead  = |dead_vec;

endmodule

// ===== design/price_time_order_book.sv =====
// Top level of the two-sided price-time order book.
//
// Request channel: func, side, price and order_id are taken at a rising edge
// with start high and busy low. busy stays high until the result is shown.
// Result channel: done is high for exactly one cycle with status and the best
// bid and ask (price and id, zero when the side is empty, with valid flags).
// The receiver cannot stall, so every result is taken in its done cycle.
//
// Each side is a row of BOOK_DEPTH cells kept sorted, best order in cell 0.
// An add is applied in one step by every cell at once: cells behind the new
// price pull from their lower neighbor. EXEC is followed by REPORT, which
// shows done; the next request can be taken in the cycle after done.
// A remove first marks matching cells, then closes one gap per cycle as the
// cells behind the first mark pull from their upper neighbor. COMPACT lasts
// until no mark is left; REPORT follows (straight from EXEC if none match).
// Reset empties both sides at once and leaves the block idle.
module price_time_order_book (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        func,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] order_id,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic        bid_valid,
  output logic [31:0] best_bid_price,
  output logic [31:0] best_bid_id,
  output logic        ask_valid,
  output logic [31:0] best_ask_price,
  output logic [31:0] best_ask_id
);

  ptob_pkg::state_t  state, state_next;
  ptob_pkg::status_t status_q, status_q_next;
  logic                         op_remove;
  logic                         op_ask;
  logic [ptob_pkg::PRICE_W-1:0] key_price;
  logic [ptob_pkg::ID_W-1:0]    key_id;

  logic ins_en, mark_en, shift_en;
  ptob_pkg::cmd_t        cmd_bid, cmd_ask;
  ptob_pkg::entry_t      head_bid, head_ask;
  ptob_pkg::chain_stat_t stat_bid, stat_ask, stat_sel;
  logic accept;

  assign accept   = start && !busy;
  assign stat_sel = op_ask ? stat_ask : stat_bid;

  // next state
  always_comb begin
    state_next    = state;
    status_q_next = status_q;
    case (state)
      ptob_pkg::ST_IDLE: begin
        if (start) state_next = ptob_pkg::ST_EXEC;
      end
      ptob_pkg::ST_EXEC: begin
        if (op_remove) begin
          if (stat_sel.any_match) begin
            state_next    = ptob_pkg::ST_COMPACT;
            status_q_next = ptob_pkg::STATUS_DONE;
          end else begin
            state_next    = ptob_pkg::ST_REPORT;
            status_q_next = ptob_pkg::STATUS_NOT_FOUND;
          end
        end else begin
          state_next    = ptob_pkg::ST_REPORT;
          status_q_next = stat_sel.full ? ptob_pkg::STATUS_FULL : ptob_pkg::STATUS_DONE;
        end
      end
      ptob_pkg::ST_COMPACT: begin
        if (!stat_sel.any_dead) state_next = ptob_pkg::ST_REPORT;
      end
      ptob_pkg::ST_REPORT: begin
        state_next = ptob_pkg::ST_IDLE;
      end
      default: begin
        state_next = ptob_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ins_en   = 1'b0;
    mark_en  = 1'b0;
    shift_en = 1'b0;
    busy     = 1'b1;
    done     = 1'b0;
    case (state)
      ptob_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      ptob_pkg::ST_EXEC: begin
        mark_en = op_remove;
        ins_en  = !op_remove && !stat_sel.full;
      end
      ptob_pkg::ST_COMPACT: begin
        shift_en = stat_sel.any_dead;
      end
      ptob_pkg::ST_REPORT: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ptob_pkg::ST_IDLE;
      status_q <= ptob_pkg::STATUS_DONE;
    end else begin
      state    <= state_next;
      status_q <= status_q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_remove <= func;
      op_ask    <= side;
      key_price <= price;
      key_id    <= order_id;
    end
  end

  always_comb begin
    cmd_bid.ins_en    = ins_en && !op_ask;
    cmd_bid.mark_en   = mark_en && !op_ask;
    cmd_bid.shift_en  = shift_en && !op_ask;
    cmd_bid.key_price = key_price;
    cmd_bid.key_id    = key_id;
    cmd_ask.ins_en    = ins_en && op_ask;
    cmd_ask.mark_en   = mark_en && op_ask;
    cmd_ask.shift_en  = shift_en && op_ask;
    cmd_ask.key_price = key_price;
    cmd_ask.key_id    = key_id;
  end

  ptob_chain u_bid (
    .clk    (clk),
    .rst    (rst),
    .is_ask (1'b0),
    .cmd    (cmd_bid),
    .head   (head_bid),
    .stat   (stat_bid)
  );

  ptob_chain u_ask (
    .clk    (clk),
    .rst    (rst),
    .is_ask (1'b1),
    .cmd    (cmd_ask),
    .head   (head_ask),
    .stat   (stat_ask)
  );

  assign status         = status_q;
  assign bid_valid      = head_bid.valid;
  assign best_bid_price = head_bid.valid ? head_bid.price : '0;
  assign best_bid_id    = head_bid.valid ? head_bid.id : '0;
  assign ask_valid      = head_ask.valid;
  assign best_ask_price = head_ask.valid ? head_ask.price : '0;
  assign best_ask_id    = head_ask.valid ? head_ask.id : '0;

endmodule

// ===== design/ptob_checker.sv =====
// Port-level checks for the order book, bound to the top level.
module ptob_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        bid_valid,
  input logic [31:0] best_bid_price,
  input logic [31:0] best_bid_id,
  input logic        ask_valid,
  input logic [31:0] best_ask_price,
  input logic [31:0] best_ask_id
);

  // an accepted request must raise busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // a result ends the request: no second result back to back
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result not followed by idle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && (status == ptob_pkg::STATUS_DONE || status == ptob_pkg::STATUS_FULL ||
                      status == ptob_pkg::STATUS_NOT_FOUND))
    else $error("result outside a request or bad status");

  a_empty_bid: assert property (@(posedge clk) disable iff (rst)
    !bid_valid |-> best_bid_price == 32'd0 && best_bid_id == 32'd0)
    else $error("empty bid side shows an order");

  a_empty_ask: assert property (@(posedge clk) disable iff (rst)
    !ask_valid |-> best_ask_price == 32'd0 && best_ask_id == 32'd0)
    else $error("empty ask side shows an order");

endmodule

bind price_time_order_book ptob_checker u_ptob_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .bid_valid      (bid_valid),
  .best_bid_price (best_bid_price),
  .best_bid_id    (best_bid_id),
  .ask_valid      (ask_valid),
  .best_ask_price (best_ask_price),
  .best_ask_id    (best_ask_id)
);
